[rtl/core/tskc_pkg.sv]
// Shared types and constants for the time-set keypad controller.
package tskc_pkg;

	typedef enum logic [1:0] {
		MODE_EDIT      = 2'd0,
		MODE_CHANGED   = 2'd1,
		MODE_UNCHANGED = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		FIELD_SEC  = 2'd0,
		FIELD_MIN  = 2'd1,
		FIELD_HOUR = 2'd2
	} field_t;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_SELECT = 2'd1;
	localparam logic [1:0] ACT_ADJUST = 2'd2;

	localparam logic [1:0] REG_LONG_PRESS = 2'd0;
	localparam logic [1:0] REG_BLINK      = 2'd1;
	localparam logic [1:0] REG_MESSAGE    = 2'd2;

	localparam logic [7:0] LONG_PRESS_RESET = 8'd200;
	localparam logic [7:0] BLINK_RESET      = 8'd150;
	localparam logic [7:0] MESSAGE_RESET    = 8'd3;

	localparam int ADDR_W = 4;

	typedef struct packed {
		logic [7:0] long_press_ticks;
		logic [7:0] blink_ticks;
		logic [7:0] message_periods;
	} cfg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [4:0] cur_hours;
		logic [5:0] cur_minutes;
		logic [5:0] cur_seconds;
	} item_t;

	typedef struct packed {
		mode_t      edit_mode;
		logic       loaded;
		logic [4:0] held_hours;
		logic [5:0] held_minutes;
		logic [5:0] held_seconds;
		field_t     field_index;
		logic [7:0] select_press_count;
		logic [7:0] adjust_press_count;
		logic [7:0] blink_divider;
		logic       blink_state;
		logic [7:0] message_timeout;
	} state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic [1:0] selected_field;
		logic       blink_on;
		logic       write_strobe;
		logic [5:0] hours_bcd;
		logic [6:0] minutes_bcd;
		logic [6:0] seconds_bcd;
		logic       return_to_menu;
		logic       log_entry;
	} result_t;

endpackage

[rtl/core/tskc_if.sv]
// Valid/ready channel interfaces for key ticks and results.
interface tskc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [4:0] cur_hours;
	logic [5:0] cur_minutes;
	logic [5:0] cur_seconds;

	modport source (output valid, action, cur_hours, cur_minutes, cur_seconds, input ready);
	modport sink (input valid, action, cur_hours, cur_minutes, cur_seconds, output ready);
endinterface

interface tskc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [4:0] hours;
	logic [5:0] minutes;
	logic [5:0] seconds;
	logic [1:0] selected_field;
	logic       blink_on;
	logic       write_strobe;
	logic [5:0] hours_bcd;
	logic [6:0] minutes_bcd;
	logic [6:0] seconds_bcd;
	logic       return_to_menu;
	logic       log_entry;

	modport source (output valid, mode, hours, minutes, seconds, selected_field, blink_on,
		write_strobe, hours_bcd, minutes_bcd, seconds_bcd, return_to_menu, log_entry,
		input ready);
	modport sink (input valid, mode, hours, minutes, seconds, selected_field, blink_on,
		write_strobe, hours_bcd, minutes_bcd, seconds_bcd, return_to_menu, log_entry,
		output ready);
endinterface

[rtl/core/tskc_regs.sv]
// APB configuration registers: long press limit, blink period, message periods.
module tskc_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tskc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output tskc_pkg::cfg_t             cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.long_press_ticks <= tskc_pkg::LONG_PRESS_RESET;
			cfg.blink_ticks      <= tskc_pkg::BLINK_RESET;
			cfg.message_periods  <= tskc_pkg::MESSAGE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				tskc_pkg::REG_LONG_PRESS: cfg.long_press_ticks <= pwdata[7:0];
				tskc_pkg::REG_BLINK:      cfg.blink_ticks      <= pwdata[7:0];
				tskc_pkg::REG_MESSAGE:    cfg.message_periods  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tskc_pkg::REG_LONG_PRESS: prdata = {24'd0, cfg.long_press_ticks};
			tskc_pkg::REG_BLINK:      prdata = {24'd0, cfg.blink_ticks};
			tskc_pkg::REG_MESSAGE:    prdata = {24'd0, cfg.message_periods};
			default:                  prdata = 32'd0;
		endcase
	end

endmodule

[rtl/core/tskc_step.sv]
// Next-state and result logic for one key tick.
module tskc_step (
	input  tskc_pkg::cfg_t    cfg,
	input  tskc_pkg::item_t   item,
	input  tskc_pkg::state_t  cur,
	output tskc_pkg::state_t  nxt,
	output tskc_pkg::result_t res
);

	logic [7:0] sel_inc;
	logic [7:0] adj_inc;
	logic [7:0] hb;
	logic [7:0] mb;
	logic [7:0] sb;

	// tens by compare chain, units by one subtract; input is at most 63
	function automatic logic [7:0] to_bcd(input logic [5:0] v);
		logic [2:0] tens;
		logic [5:0] units;
		if (v >= 6'd60)      tens = 3'd6;
		else if (v >= 6'd50) tens = 3'd5;
		else if (v >= 6'd40) tens = 3'd4;
		else if (v >= 6'd30) tens = 3'd3;
		else if (v >= 6'd20) tens = 3'd2;
		else if (v >= 6'd10) tens = 3'd1;
		else                 tens = 3'd0;
		units = v - 6'({tens, 3'b000} + {2'b00, tens, 1'b0});
		return {1'b0, tens, units[3:0]};
	endfunction

	function automatic logic [5:0] inc_mod60(input logic [5:0] v);
		logic [6:0] s;
		s = {1'b0, v} + 7'd1;
		if (s >= 7'd60) s = s - 7'd60;
		return s[5:0];
	endfunction

	function automatic logic [4:0] inc_mod24(input logic [4:0] v);
		logic [5:0] s;
		s = {1'b0, v} + 6'd1;
		if (s >= 6'd24) s = s - 6'd24;
		return s[4:0];
	endfunction

	assign sel_inc = cur.select_press_count + 8'd1;
	assign adj_inc = cur.adjust_press_count + 8'd1;

	always_comb begin
		nxt = cur;
		hb  = 8'd0;
		mb  = 8'd0;
		sb  = 8'd0;
		res = '0;
		case (cur.edit_mode)
			tskc_pkg::MODE_CHANGED, tskc_pkg::MODE_UNCHANGED: begin
				nxt.loaded = 1'b0;
				if (cur.message_timeout == 8'd0) begin
					nxt.edit_mode = tskc_pkg::MODE_EDIT;
					res.return_to_menu = 1'b1;
				end
			end
			default: begin
				if (!cur.loaded) begin
					nxt.held_hours   = item.cur_hours;
					nxt.held_minutes = item.cur_minutes;
					nxt.held_seconds = item.cur_seconds;
					nxt.loaded       = 1'b1;
					res.log_entry    = 1'b1;
				end
				if (item.action == tskc_pkg::ACT_SELECT) begin
					nxt.select_press_count = sel_inc;
					if (sel_inc > cfg.long_press_ticks) begin
						nxt.select_press_count = 8'd0;
						hb = to_bcd({1'b0, nxt.held_hours});
						mb = to_bcd(nxt.held_minutes);
						sb = to_bcd(nxt.held_seconds);
						res.write_strobe    = 1'b1;
						nxt.message_timeout = cfg.message_periods;
						nxt.edit_mode       = tskc_pkg::MODE_CHANGED;
					end
				end else if (cur.select_press_count < cfg.long_press_ticks &&
						cur.select_press_count != 8'd0) begin
					case (cur.field_index)
						tskc_pkg::FIELD_SEC:  nxt.field_index = tskc_pkg::FIELD_MIN;
						tskc_pkg::FIELD_MIN:  nxt.field_index = tskc_pkg::FIELD_HOUR;
						tskc_pkg::FIELD_HOUR: nxt.field_index = tskc_pkg::FIELD_SEC;
						default:              nxt.field_index = tskc_pkg::FIELD_MIN;
					endcase
					nxt.select_press_count = 8'd0;
				end
				if (item.action == tskc_pkg::ACT_ADJUST) begin
					nxt.adjust_press_count = adj_inc;
					if (adj_inc > cfg.long_press_ticks) begin
						nxt.adjust_press_count = 8'd0;
						nxt.message_timeout    = cfg.message_periods;
						nxt.edit_mode          = tskc_pkg::MODE_UNCHANGED;
					end
				end else if (cur.adjust_press_count < cfg.long_press_ticks &&
						cur.adjust_press_count != 8'd0) begin
					// field chosen after any select step in this same tick
					case (nxt.field_index)
						tskc_pkg::FIELD_SEC:  nxt.held_seconds = inc_mod60(nxt.held_seconds);
						tskc_pkg::FIELD_MIN:  nxt.held_minutes = inc_mod60(nxt.held_minutes);
						tskc_pkg::FIELD_HOUR: nxt.held_hours   = inc_mod24(nxt.held_hours);
						default: ;
					endcase
					nxt.adjust_press_count = 8'd0;
				end
			end
		endcase

		if (cur.blink_divider == cfg.blink_ticks) begin
			nxt.blink_divider   = 8'd0;
			nxt.blink_state     = ~cur.blink_state;
			nxt.message_timeout = nxt.message_timeout - 8'd1;
		end else begin
			nxt.blink_divider = cur.blink_divider + 8'd1;
		end

		res.mode           = nxt.edit_mode;
		res.hours          = nxt.held_hours;
		res.minutes        = nxt.held_minutes;
		res.seconds        = nxt.held_seconds;
		res.selected_field = nxt.field_index;
		res.blink_on       = nxt.blink_state;
		res.hours_bcd      = hb[5:0];
		res.minutes_bcd    = mb[6:0];
		res.seconds_bcd    = sb[6:0];
	end

endmodule

[rtl/core/time_set_keypad_controller.sv]
// A tick passes through the input register, then the result register; a stalled sink can hold it between them.
// Throughput: one tick per cycle while the sink takes results; the step logic sits between the two registers.
// A result waiting on a stalled sink holds; one more tick may sit in the input register.
// Reset (arst_n low, asynchronous): editing mode, seconds field, counters and held time zero,
// registers at 200, 150 and 3; no clearing pass, ready again as soon as reset is released.
module time_set_keypad_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	tskc_in_if.sink                     keys,
	tskc_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tskc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	tskc_pkg::cfg_t    cfg;
	tskc_pkg::item_t   item_s1;
	tskc_pkg::state_t  state_q;
	tskc_pkg::state_t  state_nxt;
	tskc_pkg::result_t res_nxt;
	tskc_pkg::result_t res_q;
	logic              valid_s1;
	logic              out_valid_q;
	logic              advance;

	tskc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tskc_step u_step (
		.cfg  (cfg),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign advance    = valid_s1 & (~out_valid_q | result.ready);
	// no transfer is taken while reset is held
	assign keys.ready = arst_n & (~valid_s1 | advance);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (keys.ready) valid_s1 <= keys.valid;
			if (advance) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			item_s1.action      <= keys.action;
			item_s1.cur_hours   <= keys.cur_hours;
			item_s1.cur_minutes <= keys.cur_minutes;
			item_s1.cur_seconds <= keys.cur_seconds;
		end
		if (advance) res_q <= res_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				edit_mode:          tskc_pkg::MODE_EDIT,
				loaded:             1'b0,
				held_hours:         5'd0,
				held_minutes:       6'd0,
				held_seconds:       6'd0,
				field_index:        tskc_pkg::FIELD_SEC,
				select_press_count: 8'd0,
				adjust_press_count: 8'd0,
				blink_divider:      8'd0,
				blink_state:        1'b0,
				message_timeout:    8'd0
			};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.mode           = res_q.mode;
	assign result.hours          = res_q.hours;
	assign result.minutes        = res_q.minutes;
	assign result.seconds        = res_q.seconds;
	assign result.selected_field = res_q.selected_field;
	assign result.blink_on       = res_q.blink_on;
	assign result.write_strobe   = res_q.write_strobe;
	assign result.hours_bcd      = res_q.hours_bcd;
	assign result.minutes_bcd    = res_q.minutes_bcd;
	assign result.seconds_bcd    = res_q.seconds_bcd;
	assign result.return_to_menu = res_q.return_to_menu;
	assign result.log_entry      = res_q.log_entry;

endmodule

[rtl/core/tskc_checker.sv]
// Port-level checks for the time-set keypad controller, bound to the top level.
module tskc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] mode,
	input logic       write_strobe,
	input logic       return_to_menu,
	input logic       log_entry,
	input logic [5:0] hours_bcd,
	input logic [6:0] minutes_bcd,
	input logic [6:0] seconds_bcd
);

	// a pending result must stay offered until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// with the result register empty the input side can never be stalled
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_strobe_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_strobe |-> mode != tskc_pkg::MODE_EDIT)
		else $error("save strobe without message mode");

	a_bcd_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_strobe |->
			hours_bcd == 6'd0 && minutes_bcd == 7'd0 && seconds_bcd == 7'd0)
		else $error("BCD values without save strobe");

	a_return_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && return_to_menu |->
			mode == tskc_pkg::MODE_EDIT && !write_strobe && !log_entry)
		else $error("return to menu with other events");

endmodule

bind time_set_keypad_controller tskc_checker u_tskc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (keys.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.mode           (result.mode),
	.write_strobe   (result.write_strobe),
	.return_to_menu (result.return_to_menu),
	.log_entry      (result.log_entry),
	.hours_bcd      (result.hours_bcd),
	.minutes_bcd    (result.minutes_bcd),
	.seconds_bcd    (result.seconds_bcd)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the time-set keypad controller: tick stimulus, APB setup, result check.
module tb_top;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	class clock_edit_tracker;
		logic [7:0] long_lim, blink_per, msg_per;
		tskc_pkg::mode_t mode_q;
		bit         latched;
		logic [4:0] hh;
		logic [5:0] mm, ss;
		logic [1:0] fld;
		logic [7:0] sel_cnt, adj_cnt, div_cnt, msg_left;
		bit         blink;
		tskc_pkg::result_t due_results[$];
		int         mismatches;

		function new();
			long_lim = tskc_pkg::LONG_PRESS_RESET;
			blink_per = tskc_pkg::BLINK_RESET;
			msg_per = tskc_pkg::MESSAGE_RESET;
			mode_q = tskc_pkg::MODE_EDIT;
			latched = 0;
			hh = '0;
			mm = '0;
			ss = '0;
			fld = tskc_pkg::FIELD_SEC;
			sel_cnt = '0;
			adj_cnt = '0;
			div_cnt = '0;
			msg_left = '0;
			blink = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] v);
			case (idx)
				tskc_pkg::REG_LONG_PRESS: long_lim = v;
				tskc_pkg::REG_BLINK: blink_per = v;
				tskc_pkg::REG_MESSAGE: msg_per = v;
				default: ;
			endcase
		endfunction

		function logic [7:0] to_bcd(logic [7:0] v);
			return {4'(v / 10), 4'(v % 10)};
		endfunction

		// Returns 1 when the tick arrived while editing (i.e. its key action was not ignored).
		function bit note_tick(tskc_pkg::item_t it);
			tskc_pkg::result_t r;
			bit editing;
			r = '0;
			editing = !(mode_q == tskc_pkg::MODE_CHANGED || mode_q == tskc_pkg::MODE_UNCHANGED);
			if (!editing) begin
				latched = 0;
				if (msg_left == 8'd0) begin
					mode_q = tskc_pkg::MODE_EDIT;
					r.return_to_menu = 1'b1;
				end
			end else begin
				if (!latched) begin
					hh = it.cur_hours;
					mm = it.cur_minutes;
					ss = it.cur_seconds;
					latched = 1;
					r.log_entry = 1'b1;
				end
				if (it.action == tskc_pkg::ACT_SELECT) begin
					sel_cnt = sel_cnt + 8'd1;
					if (sel_cnt > long_lim) begin
						sel_cnt = '0;
						r.write_strobe = 1'b1;
						r.hours_bcd = 6'(to_bcd(8'(hh)));
						r.minutes_bcd = 7'(to_bcd(8'(mm)));
						r.seconds_bcd = 7'(to_bcd(8'(ss)));
						msg_left = msg_per;
						mode_q = tskc_pkg::MODE_CHANGED;
					end
				end else if (sel_cnt < long_lim && sel_cnt != 8'd0) begin
					fld = 2'((fld + 1) % 3);
					sel_cnt = '0;
				end
				if (it.action == tskc_pkg::ACT_ADJUST) begin
					adj_cnt = adj_cnt + 8'd1;
					if (adj_cnt > long_lim) begin
						adj_cnt = '0;
						msg_left = msg_per;
						mode_q = tskc_pkg::MODE_UNCHANGED;
					end
				end else if (adj_cnt < long_lim && adj_cnt != 8'd0) begin
					case (fld)
						tskc_pkg::FIELD_SEC: ss = 6'((ss + 1) % 60);
						tskc_pkg::FIELD_MIN: mm = 6'((mm + 1) % 60);
						tskc_pkg::FIELD_HOUR: hh = 5'((hh + 1) % 24);
						default: ;
					endcase
					adj_cnt = '0;
				end
			end
			if (div_cnt == blink_per) begin
				div_cnt = '0;
				blink = !blink;
				msg_left = msg_left - 8'd1;
			end else begin
				div_cnt = div_cnt + 8'd1;
			end
			r.mode = mode_q;
			r.hours = hh;
			r.minutes = mm;
			r.seconds = ss;
			r.selected_field = fld;
			r.blink_on = blink;
			due_results.push_back(r);
			return editing;
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
		endfunction

		function void cmp(string what, logic [7:0] want, logic [7:0] got);
			if (want !== got)
				flag(what, want, got);
		endfunction

		function void check_result(tskc_pkg::result_t got);
			tskc_pkg::result_t want;
			if (due_results.size() == 0) begin
				flag("unexpected result transfer", 0, 1);
				return;
			end
			want = due_results.pop_front();
			cmp("mode", want.mode, got.mode);
			cmp("hours", want.hours, got.hours);
			cmp("minutes", want.minutes, got.minutes);
			cmp("seconds", want.seconds, got.seconds);
			cmp("selected_field", want.selected_field, got.selected_field);
			cmp("blink_on", want.blink_on, got.blink_on);
			cmp("write_strobe", want.write_strobe, got.write_strobe);
			cmp("hours_bcd", want.hours_bcd, got.hours_bcd);
			cmp("minutes_bcd", want.minutes_bcd, got.minutes_bcd);
			cmp("seconds_bcd", want.seconds_bcd, got.seconds_bcd);
			cmp("return_to_menu", want.return_to_menu, got.return_to_menu);
			cmp("log_entry", want.log_entry, got.log_entry);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite, pready;
	logic [tskc_pkg::ADDR_W-1:0] paddr;
	logic [31:0]       pwdata, prdata;
	int                send_idle, recv_idle;
	int                cycle_count;

	clock_edit_tracker edit_track = new();

	tskc_in_if  keys_if();
	tskc_out_if res_if();

	time_set_keypad_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.keys(keys_if),
		.result(res_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	// Result side: check on each transfer, then pick the next ready value.
	always @(posedge clk) begin
		if (res_if.valid && res_if.ready)
			edit_track.check_result({res_if.mode, res_if.hours, res_if.minutes, res_if.seconds,
				res_if.selected_field, res_if.blink_on, res_if.write_strobe, res_if.hours_bcd,
				res_if.minutes_bcd, res_if.seconds_bcd, res_if.return_to_menu,
				res_if.log_entry});
		res_if.ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_tick(logic [1:0] act, logic [4:0] h, logic [5:0] m, logic [5:0] s,
		output bit editing);
		tskc_pkg::item_t it;
		it = {act, h, m, s};
		while ($urandom_range(99) < send_idle) begin
			keys_if.valid <= 1'b0;
			@(posedge clk);
		end
		keys_if.valid <= 1'b1;
		keys_if.action <= act;
		keys_if.cur_hours <= h;
		keys_if.cur_minutes <= m;
		keys_if.cur_seconds <= s;
		do @(posedge clk); while (!keys_if.ready);
		editing = edit_track.note_tick(it);
	endtask

	// Mostly legal clock values, now and then anything the field widths allow.
	task automatic send_key(logic [1:0] act, output bit editing);
		logic [4:0] h;
		logic [5:0] m, s;
		if ($urandom_range(4) == 0) begin
			h = 5'($urandom_range(31));
			m = 6'($urandom_range(63));
			s = 6'($urandom_range(63));
		end else begin
			h = 5'($urandom_range(23));
			m = 6'($urandom_range(59));
			s = 6'($urandom_range(59));
		end
		send_tick(act, h, m, s, editing);
	endtask

	task automatic sit_out_message();
		bit ed;
		while (edit_track.mode_q != tskc_pkg::MODE_EDIT)
			send_key(ACT_UNUSED, ed);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		edit_track.set_reg(idx, v);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		edit_track.cmp("register readback", v, prdata[7:0]);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [7:0] lp, logic [7:0] bl, logic [7:0] msg);
		apb_write(tskc_pkg::REG_LONG_PRESS, lp);
		apb_write(tskc_pkg::REG_BLINK, bl);
		apb_write(tskc_pkg::REG_MESSAGE, msg);
	endtask

	// Drain every outstanding result with the key input idle, then wait for the pipeline.
	task automatic settle();
		keys_if.valid <= 1'b0;
		while (edit_track.due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Needs long press limit 2: covers field change, increments and wraps, the
	// exact-limit hold, save and cancel with the other key's short press pending.
	task automatic directed_ticks();
		bit ed;
		sit_out_message();
		send_tick(tskc_pkg::ACT_NONE, 5'd31, 6'd63, 6'd63, ed);
		send_key(tskc_pkg::ACT_SELECT, ed);
		send_key(tskc_pkg::ACT_NONE, ed);
		send_key(tskc_pkg::ACT_ADJUST, ed);
		send_key(tskc_pkg::ACT_NONE, ed);
		send_key(tskc_pkg::ACT_SELECT, ed);
		send_key(tskc_pkg::ACT_SELECT, ed);
		send_key(tskc_pkg::ACT_NONE, ed);
		send_key(tskc_pkg::ACT_ADJUST, ed);
		send_key(tskc_pkg::ACT_SELECT, ed);
		sit_out_message();
		send_tick(tskc_pkg::ACT_NONE, 5'd23, 6'd59, 6'd59, ed);
		send_key(tskc_pkg::ACT_SELECT, ed);
		send_key(ACT_UNUSED, ed);
		send_key(tskc_pkg::ACT_ADJUST, ed);
		send_key(tskc_pkg::ACT_NONE, ed);
		send_key(tskc_pkg::ACT_SELECT, ed);
		send_key(tskc_pkg::ACT_NONE, ed);
		send_key(tskc_pkg::ACT_ADJUST, ed);
		send_key(tskc_pkg::ACT_NONE, ed);
		send_key(tskc_pkg::ACT_ADJUST, ed);
		send_key(tskc_pkg::ACT_ADJUST, ed);
		send_key(tskc_pkg::ACT_SELECT, ed);
		send_key(tskc_pkg::ACT_ADJUST, ed);
		sit_out_message();
	endtask

	// Key presses of random length around the long-press limit, short releases between,
	// and a sprinkling of single noise ticks. Every tick sent counts, messages included.
	task automatic run_random(int budget);
		int done, len, r, lim;
		bit ed;
		logic [1:0] key;
		done = 0;
		while (done < budget) begin
			r = $urandom_range(99);
			if (r < 10) begin
				send_key(2'($urandom_range(3)), ed);
				done++;
			end else begin
				key = $urandom_range(1) ? tskc_pkg::ACT_SELECT : tskc_pkg::ACT_ADJUST;
				lim = edit_track.long_lim;
				r = $urandom_range(99);
				if (r < 45)
					len = $urandom_range(lim > 1 ? lim - 1 : 1, 1);
				else if (r < 60)
					len = lim;
				else
					len = $urandom_range(lim + 3, lim + 1);
				repeat (len) begin
					send_key(key, ed);
					done++;
				end
				repeat ($urandom_range(2)) begin
					send_key(($urandom_range(3) == 0) ? ACT_UNUSED : tskc_pkg::ACT_NONE, ed);
					done++;
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		keys_if.valid <= 1'b0;
		keys_if.action <= tskc_pkg::ACT_NONE;
		keys_if.cur_hours <= '0;
		keys_if.cur_minutes <= '0;
		keys_if.cur_seconds <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		send_idle = 36;
		recv_idle = 68;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values first
		run_random(40);
		settle();
		configure(8'd2, 8'd1, 8'd1);
		directed_ticks();
		settle();
		configure(8'd3, 8'd2, 8'd2);
		run_random(190);
		settle();
		configure(8'd1, 8'd1, 8'd1);
		run_random(180);
		settle();

		send_idle = 68;
		recv_idle = 36;
		configure(8'd5, 8'd7, 8'd4);
		run_random(180);
		settle();
		configure(8'd254, 8'd3, 8'd2);
		run_random(200);
		settle();
		configure(8'd2, 8'd255, 8'd1);
		run_random(170);
		settle();

		// divider now well past the new period: it has to wrap round first
		send_idle = 0;
		recv_idle = 0;
		configure(8'd4, 8'd1, 8'd255);
		run_random(170);
		settle();
		configure(8'd6, 8'd5, 8'd3);
		run_random(170);
		settle();

		if (edit_track.mismatches == 0 && edit_track.due_results.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
